// File: hw/rtl/slfc_pkg.sv
package slfc_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AtanEntries = 24;

  localparam logic signed [35:0] PiQ30        = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30    = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30     = 36'sd6746518852;
  localparam logic signed [31:0] TwoOverPiQ30 = 32'sd683565276;
  localparam logic signed [31:0] QuarterPiQ30 = 32'sd843314857;
  localparam logic signed [31:0] KinvQ30      = 32'sd652032874;
  localparam logic signed [31:0] KinvQ24      = 32'sd10188013;
  localparam logic signed [35:0] OneQ30       = 36'sd1073741824;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_END_X    = 3'd2,
    REG_END_Y    = 3'd3,
    REG_SAIL     = 3'd4,
    REG_APPROACH = 3'd5,
    REG_RUDDER   = 3'd6
  } cfg_idx_t;

  // atan(2^-i) in Q30
  function automatic logic signed [35:0] atan_lut(input logic [4:0] i);
    logic signed [35:0] v;
    case (i)
      5'd0: v = 36'sd843314857;
      5'd1: v = 36'sd497837829;
      5'd2: v = 36'sd263043837;
      5'd3: v = 36'sd133525159;
      5'd4: v = 36'sd67021687;
      5'd5: v = 36'sd33543516;
      5'd6: v = 36'sd16775851;
      5'd7: v = 36'sd8388437;
      5'd8: v = 36'sd4194283;
      5'd9: v = 36'sd2097149;
      default: v = 36'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/slfc_if.sv
interface slfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [15:0] wind_dir;
  modport source (output valid, pos_x, pos_y, heading, wind_dir, input ready);
  modport sink (input valid, pos_x, pos_y, heading, wind_dir, output ready);
endinterface

interface slfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rudder_cmd;
  logic        [14:0] sail_cmd;
  logic               line_degenerate;
  modport source (output valid, rudder_cmd, sail_cmd, line_degenerate, input ready);
  modport sink (input valid, rudder_cmd, sail_cmd, line_degenerate, output ready);
endinterface

interface slfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/slfc_sincos.sv
// pipelined rotation-mode cordic, one iteration per stage, returns cos and sin in Q30
module slfc_sincos #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] ang,
  output logic signed [35:0] cos_o,
  output logic signed [35:0] sin_o
);
  import slfc_pkg::*;

  localparam logic signed [35:0] ThreePiQ30 = PiQ30 + TwoPiQ30;
  localparam logic signed [35:0] FourPiQ30  = TwoPiQ30 + TwoPiQ30;

  logic signed [35:0] x_r [CORDIC_STEPS+1];
  logic signed [35:0] y_r [CORDIC_STEPS+1];
  logic signed [35:0] z_r [CORDIC_STEPS+1];
  logic               f_r [CORDIC_STEPS+1];
  logic signed [35:0] red_nxt;
  logic               flip_nxt;

  // reduce to [-pi, pi), input spans up to two turns either way,
  // then fold into [-pi/2, pi/2]
  always_comb begin
    red_nxt  = ang;
    flip_nxt = 1'b0;
    if (red_nxt >= ThreePiQ30) red_nxt = red_nxt - FourPiQ30;
    else if (red_nxt >= PiQ30) red_nxt = red_nxt - TwoPiQ30;
    if (red_nxt < -ThreePiQ30) red_nxt = red_nxt + FourPiQ30;
    else if (red_nxt < -PiQ30) red_nxt = red_nxt + TwoPiQ30;
    if (red_nxt > HalfPiQ30) begin
      red_nxt  = red_nxt - PiQ30;
      flip_nxt = 1'b1;
    end else if (red_nxt < -HalfPiQ30) begin
      red_nxt  = red_nxt + PiQ30;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= 36'(KinvQ30);
      y_r[0] <= '0;
      z_r[0] <= red_nxt;
      f_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_lut(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_lut(5'(i));
        end
      end
    end
  end

  assign cos_o = f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign sin_o = f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];

endmodule

// File: hw/rtl/sail_line_following_control_top.sv
// channel | dir | transfer                   | payload
// in      | in  | in_valid & in_ready        | pos_x, pos_y, heading, wind_dir
// out     | out | out_valid & out_ready      | rudder_cmd, sail_cmd, line_degenerate
// cfg     | in  | cfg_valid & cfg_ready      | index, data
// one item per cycle sustained while the output is not stalled; the path runs through three
// cordic pipelines in series (line vectoring, atan vectoring, sin/cos)
// reset clears the valid bits and sets the configuration registers to their reset values
// the whole pipeline advances when the output register is empty or taken
module sail_line_following_control_top #(
  parameter int CORDIC_STEPS = slfc_pkg::CordicStepsDef
) (
  input logic clk,
  input logic rst_n,
  slfc_in_if.sink    in_ch,
  slfc_out_if.source out_ch,
  slfc_cfg_if.sink   cfg_ch
);
  import slfc_pkg::*;

  localparam int N = CORDIC_STEPS;
  localparam int LAT = 3 * N + 9;

  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic [15:0] ks_r;
  logic [14:0] gam_r, urm_r;

  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0;
      ks_r <= 16'd4096; gam_r <= 15'd6434; urm_r <= 15'd6434;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START_X:  sx_r <= cfg_ch.data;
        REG_START_Y:  sy_r <= cfg_ch.data;
        REG_END_X:    ex_r <= cfg_ch.data;
        REG_END_Y:    ey_r <= cfg_ch.data;
        REG_SAIL:     ks_r <= cfg_ch.data[15:0];
        REG_APPROACH: gam_r <= cfg_ch.data[14:0];
        REG_RUDDER:   urm_r <= cfg_ch.data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v_r [LAT+1];
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int k = 1; k <= LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  // heading/wind delay line up to the target heading stage
  localparam int HD = 2 * N + 7;
  logic signed [15:0] th_r [HD];
  logic signed [15:0] wd_r [HD];
  always_ff @(posedge clk) begin
    if (en) begin
      th_r[0] <= in_ch.heading;
      wd_r[0] <= in_ch.wind_dir;
      for (int k = 1; k < HD; k++) begin
        th_r[k] <= th_r[k-1];
        wd_r[k] <= wd_r[k-1];
      end
    end
  end

  // stage 0: differences and half-plane fold
  logic signed [33:0] dx_nxt, dy_nxt, mx_nxt, my_nxt;
  logic signed [45:0] lx_r [N+1];
  logic signed [45:0] ly_r [N+1];
  logic signed [45:0] qy_r [N+1];
  logic signed [45:0] qx_r [N+1];
  logic signed [35:0] lz_r [N+1];
  logic               dg_r [3*N+10];
  always_comb begin
    dx_nxt = 34'(ex_r) - 34'(sx_r);
    dy_nxt = 34'(ey_r) - 34'(sy_r);
    mx_nxt = 34'(in_ch.pos_x) - 34'(sx_r);
    my_nxt = 34'(in_ch.pos_y) - 34'(sy_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dg_r[0] <= (dx_nxt == 0) && (dy_nxt == 0);
      if (dx_nxt < 0) begin
        lx_r[0] <= 46'(-dx_nxt) <<< 8;
        ly_r[0] <= 46'(-dy_nxt) <<< 8;
        qx_r[0] <= 46'(-mx_nxt);
        qy_r[0] <= 46'(-my_nxt);
        lz_r[0] <= (dy_nxt >= 0) ? PiQ30 : -PiQ30;
      end else begin
        lx_r[0] <= 46'(dx_nxt) <<< 8;
        ly_r[0] <= 46'(dy_nxt) <<< 8;
        qx_r[0] <= 46'(mx_nxt);
        qy_r[0] <= 46'(my_nxt);
        lz_r[0] <= '0;
      end
    end
  end

  // line vectoring stages
  for (genvar i = 0; i < N; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (en) begin
        if (ly_r[i] >= 0) begin
          lx_r[i+1] <= lx_r[i] + (ly_r[i] >>> i);
          ly_r[i+1] <= ly_r[i] - (lx_r[i] >>> i);
          qx_r[i+1] <= qx_r[i] + (qy_r[i] >>> i);
          qy_r[i+1] <= qy_r[i] - (qx_r[i] >>> i);
          lz_r[i+1] <= lz_r[i] + atan_lut(5'(i));
        end else begin
          lx_r[i+1] <= lx_r[i] - (ly_r[i] >>> i);
          ly_r[i+1] <= ly_r[i] + (lx_r[i] >>> i);
          qx_r[i+1] <= qx_r[i] - (qy_r[i] >>> i);
          qy_r[i+1] <= qy_r[i] + (qx_r[i] >>> i);
          lz_r[i+1] <= lz_r[i] - atan_lut(5'(i));
        end
      end
    end
  end

  for (genvar k = 1; k < 3 * N + 10; k++) begin : g_dg
    always_ff @(posedge clk) if (en) dg_r[k] <= dg_r[k-1];
  end

  // distance scaling: stage N+1 product, N+2 round; phi carried
  localparam int PD = N + 6;
  logic signed [35:0] phi_r [PD];
  logic signed [69:0] ep_r;
  logic signed [45:0] e_r;
  always_ff @(posedge clk) begin
    if (en) begin
      phi_r[0] <= dg_r[N] ? 36'sd0 : lz_r[N];
      ep_r <= dg_r[N] ? 70'sd0 : 70'($signed(qy_r[N][37:0])) * 70'(KinvQ24);
      for (int k = 1; k < PD; k++) phi_r[k] <= phi_r[k-1];
      e_r <= 46'((ep_r + (70'sd1 <<< 23)) >>> 24);
    end
  end

  // atan vectoring on (2^25, e*256)
  logic signed [47:0] ax_r [N+1];
  logic signed [47:0] ay_r [N+1];
  logic signed [35:0] az_r [N+1];
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= 48'sd33554432;
      ay_r[0] <= 48'(e_r) <<< 8;
      az_r[0] <= '0;
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_atan
    always_ff @(posedge clk) begin
      if (en) begin
        if (ay_r[i] >= 0) begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] + atan_lut(5'(i));
        end else begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] - atan_lut(5'(i));
        end
      end
    end
  end

  // gamma term over three stages, then target heading differences
  logic signed [52:0] g1_r;
  logic signed [39:0] g2_r;
  logic signed [71:0] g3_r;
  logic signed [35:0] tb_nxt;
  logic signed [35:0] dth_r, dwd_r;
  always_comb begin
    tb_nxt = phi_r[PD-1] - 36'((g3_r + (72'sd1 <<< 29)) >>> 30);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g1_r <= 53'($signed({1'b0, gam_r})) * 53'(az_r[N]);
      g2_r <= 40'((g1_r + 53'sd4096) >>> 13);
      g3_r <= 72'(g2_r) * 72'(TwoOverPiQ30);
      dth_r <= (36'(th_r[HD-1]) <<< 17) - tb_nxt;
      dwd_r <= (36'(wd_r[HD-1]) <<< 17) - tb_nxt;
    end
  end

  logic signed [35:0] rc, rs, wc, ws;
  slfc_sincos #(.CORDIC_STEPS(N)) u_rud (
    .clk(clk), .en(en), .ang(dth_r), .cos_o(rc), .sin_o(rs));
  slfc_sincos #(.CORDIC_STEPS(N)) u_sail (
    .clk(clk), .en(en), .ang(dwd_r), .cos_o(wc), .sin_o(ws));

  // output arithmetic: products, then round and saturate
  logic signed [52:0] up_r;
  logic               usat_r, uneg_r;
  logic signed [68:0] sp_r;
  logic signed [15:0] ur_nxt;
  logic signed [40:0] sc_nxt;
  logic signed [56:0] sm_nxt;
  logic [14:0]        us_nxt;
  always_ff @(posedge clk) begin
    if (en) begin
      up_r   <= 53'($signed({1'b0, urm_r})) * 53'(rs);
      usat_r <= rc < 0;
      uneg_r <= rs < 0;
      sp_r   <= 69'(wc + OneQ30) * 69'(QuarterPiQ30);
    end
  end
  always_comb begin
    if (usat_r) ur_nxt = uneg_r ? -16'($signed({1'b0, urm_r})) : 16'($signed({1'b0, urm_r}));
    else ur_nxt = 16'((up_r + (53'sd1 <<< 29)) >>> 30);
    sc_nxt = 41'((sp_r + (69'sd1 <<< 29)) >>> 30);
    sm_nxt = 57'($signed({1'b0, ks_r})) * 57'(sc_nxt);
    sm_nxt = (sm_nxt + (57'sd1 <<< 28)) >>> 29;
    if (sm_nxt < 0) us_nxt = '0;
    else if (sm_nxt > 57'sd32767) us_nxt = 15'h7fff;
    else us_nxt = sm_nxt[14:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= v_r[LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.rudder_cmd      <= ur_nxt;
      out_ch.sail_cmd        <= us_nxt;
      out_ch.line_degenerate <= dg_r[3*N+9];
    end
  end

  logic unused_ok;
  assign unused_ok = ^{ws, lx_r[N], ly_r[N], qx_r[N], ax_r[N], ay_r[N], v_r[0]};

endmodule
